FILE: src/lax_pkg.sv
// Package for the Lax-Friedrichs 1D Euler step block.
// Holds shared widths, defaults and register indexes.
package lax_pkg;
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int GAMMA_BITS = 18;
	localparam int DT_BITS = 17;
	localparam int REG_IDX_BITS = 1;
	localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = 18'd91750;
	localparam logic [DT_BITS-1:0] DT_RESET = 17'd32768;
	localparam logic [REG_IDX_BITS-1:0] REG_GAMMA = 1'b0;
	localparam logic [REG_IDX_BITS-1:0] REG_DT = 1'b1;
endpackage

FILE: src/lax_euler_1d_step.sv
// Top level of the Lax-Friedrichs 1D Euler step block.
// Depends on lax_pkg for register indexes and defaults.
//
// The block takes one grid cell per input transaction and, once the window is
// filled, returns the Lax-Friedrichs update of the middle cell; the last cell of a
// longer row returns two transactions. A shared multiplier, a separate update
// multiplier and a restoring divider that retires one quotient bit per cycle are
// stepped by a small sequencer, and s_tready is low while a cell is in work. A
// middle cell passes through a setup step, the density division, the multiplier
// products, the flux, the update of its three components and the load of the
// output register, then a shift of the window. The first cell of a longer row
// gives no result, a single-cell row gives one, and a row end gives a second
// result after the first. A density of zero or less skips the division. Results
// leave through a one-deep output register; the next cell is taken while a
// result still waits there, and the sequencer stalls only when it has a new
// result before the held one has been taken. Configuration writes are taken in
// any cycle; they must only be made while the block is idle.
module lax_euler_1d_step #(
	parameter int WORD_BITS = lax_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = lax_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// tdata: density, momentum, energy (lowest bits first), zero-padded to bytes
	input  logic [((3*WORD_BITS+7)/8)*8-1:0] s_tdata,
	// tuser: row_first, row_last
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// tdata: density_next, momentum_next, energy_next, zero-padded to bytes
	output logic [((3*WORD_BITS+7)/8)*8-1:0] m_tdata,
	// tuser: end_of_row, bad_density
	output logic [1:0] m_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [lax_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0] cfg_data
);
	import lax_pkg::*;

	localparam int W = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int TW = ((3*W+7)/8)*8;
	localparam int PW = 2*W + 2;   // product/sum working width
	localparam int DW = W + F + 2; // dividend width
	localparam int CW = $clog2(DW+1);
	localparam logic signed [W-1:0] LIM_HI = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] LIM_LO = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] ONE = W'(64'sd1 <<< F);
	localparam logic signed [W-1:0] HALF = W'(64'sd1 <<< (F-1));

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_DIV   = 11'b00000000010,
		ST_MUL   = 11'b00000000100,
		ST_EMIT  = 11'b00000001000,
		ST_OUT   = 11'b00000010000,
		ST_PRE   = 11'b00000100000,
		ST_FLUX  = 11'b00001000000,
		ST_WIN   = 11'b00010000000,
		ST_CON   = 11'b00100000000,
		ST_EMUL  = 11'b01000000000,
		ST_ESUM  = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [GAMMA_BITS-1:0] gamma_q;
	logic [DT_BITS-1:0] dt_q;

	// Operand and working registers.
	logic signed [W-1:0] c_q [3];
	logic signed [W-1:0] f_q [3];
	logic signed [W-1:0] ls_q [3], ms_q [3], lf_q [3], mf_q [3];
	logic signed [W-1:0] g_q, c1_q, c2_q, u_q, k_q, t_q [4], dtf_q;
	logic [1:0] fill_q, faults_q;
	logic bad_q, last_q, first_q, two_q, emit_last_q;
	logic [3:0] step_q;
	logic [1:0] comp_q;

	// Divider.
	logic [DW-1:0] dvd_q;
	logic [W-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic dneg_q;

	// Output register.
	logic out_v_q;
	logic [TW-1:0] out_d_q;
	logic [1:0] out_u_q;
	logic signed [W-1:0] res_q [3];
	logic out_load;

	// Gamma and dt moved to F fraction bits.
	function automatic logic signed [W-1:0] to_frac(input logic [GAMMA_BITS-1:0] x);
		logic [GAMMA_BITS+F:0] t;
		t = '0;
		if (F >= 16) t = (GAMMA_BITS+F+1)'(x) << (F-16);
		else t = ((GAMMA_BITS+F+1)'(x) + ((GAMMA_BITS+F+1)'(1) << (15-F))) >> (16-F);
		return W'(t);
	endfunction

	// Saturate a wide signed value to W bits.
	function automatic logic signed [W-1:0] sat(input logic signed [PW+F:0] v);
		if (v > (PW+F+1)'(LIM_HI)) return LIM_HI;
		if (v < (PW+F+1)'(LIM_LO)) return LIM_LO;
		return W'(v);
	endfunction

	// Round a signed value at shift s, ties away from zero.
	function automatic logic signed [PW+F:0] rshift(input logic signed [PW+F:0] v,
			input int s);
		logic [PW+F:0] mag;
		logic [PW+F:0] r;
		mag = v[PW+F] ? -v : v;
		r = (mag + ((PW+F+1)'(1) << (s-1))) >> s;
		return v[PW+F] ? -$signed(r) : $signed(r);
	endfunction

	// Shared multiplier: one product per cycle, operands selected by step.
	logic signed [W-1:0] ma, mb;
	logic signed [PW+F:0] prod;
	logic signed [W-1:0] mres;
	assign prod = (PW+F+1)'(ma) * (PW+F+1)'(mb);
	assign mres = sat(rshift(prod, F));

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (step_q)
			4'd0: begin ma = HALF; mb = 3*ONE - g_q; end
			4'd1: begin ma = HALF; mb = g_q - ONE; end
			4'd2: begin ma = c_q[1]; mb = u_q; end
			4'd3: begin ma = g_q - ONE; mb = c_q[2]; end
			4'd4: begin ma = c1_q; mb = k_q; end
			4'd5: begin ma = c_q[2]; mb = u_q; end
			4'd6: begin ma = g_q; mb = t_q[2]; end
			4'd7: begin ma = k_q; mb = u_q; end
			4'd8: begin ma = c2_q; mb = t_q[3]; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// Update arithmetic, one component at a time: a multiply state, then a sum state.
	logic signed [W-1:0] el, er, efl, efr;
	logic signed [PW+F:0] esum, edif, enum_v;
	logic signed [PW+F:0] eprod_q;
	logic signed [W-1:0] eres;
	always_comb begin
		el = emit_last_q ? ms_q[comp_q] : ls_q[comp_q];
		er = c_q[comp_q];
		efl = emit_last_q ? mf_q[comp_q] : lf_q[comp_q];
		efr = f_q[comp_q];
		if (first_q) begin
			el = c_q[comp_q];
			efl = f_q[comp_q];
		end
		esum = (PW+F+1)'(el) + (PW+F+1)'(er);
		edif = (PW+F+1)'(efr) - (PW+F+1)'(efl);
		enum_v = (esum <<< F) - eprod_q;
		eres = sat(rshift(enum_v, F+1));
	end

	logic signed [PW+F:0] fsum;
	assign fsum = (PW+F+1)'(t_q[0]) + (PW+F+1)'(t_q[1]);
	logic signed [PW+F:0] fdif;
	assign fdif = (PW+F+1)'(t_q[0]) - (PW+F+1)'(t_q[1]);

	logic [W:0] rtry;
	assign rtry = {rem_q, dvd_q[DW-1]} - {1'b0, c_q[0]};

	assign s_tready = (state_q == ST_IDLE) && !(out_v_q && two_q);
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_d_q;
	assign m_tuser = out_u_q;

	// A new result enters the output register when it is empty or being emptied.
	assign out_load = (state_q == ST_OUT) && (!out_v_q || m_tready);

	logic [TW-1:0] pack;
	always_comb begin
		pack = '0;
		pack[W-1:0] = res_q[0];
		pack[2*W-1:W] = res_q[1];
		pack[3*W-1:2*W] = res_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gamma_q <= GAMMA_RESET;
			dt_q <= DT_RESET;
			fill_q <= '0;
			faults_q <= '0;
			out_v_q <= 1'b0;
			two_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				ls_q[i] <= '0; ms_q[i] <= '0; lf_q[i] <= '0; mf_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_GAMMA: gamma_q <= cfg_data[GAMMA_BITS-1:0];
					REG_DT: dt_q <= cfg_data[DT_BITS-1:0];
					default: ;
				endcase
			end
			if (out_load) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						c_q[0] <= s_tdata[W-1:0];
						c_q[1] <= s_tdata[2*W-1:W];
						c_q[2] <= s_tdata[3*W-1:2*W];
						first_q <= s_tuser[0] || (fill_q == 2'd0);
						last_q <= s_tuser[1];
						g_q <= to_frac(gamma_q);
						dtf_q <= to_frac(GAMMA_BITS'(dt_q));
						state_q <= ST_PRE;
					end
				end
				ST_PRE: begin
					bad_q <= c_q[0][W-1] || (c_q[0] == '0);
					dneg_q <= c_q[1][W-1];
					dvd_q <= DW'(c_q[1][W-1] ? -(DW'(c_q[1])) : DW'($unsigned(c_q[1])))
						<< F;
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= CW'(DW);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (c_q[0][W-1] || c_q[0] == '0) begin
						u_q <= c_q[1][W-1] ? LIM_LO : (c_q[1] == '0 ? '0 : LIM_HI);
						step_q <= '0;
						state_q <= ST_MUL;
					end else if (cnt_q != '0) begin
						if (!rtry[W]) begin
							rem_q <= rtry[W-1:0];
							quo_q <= {quo_q[DW-2:0], 1'b1};
						end else begin
							rem_q <= {rem_q[W-2:0], dvd_q[DW-1]};
							quo_q <= {quo_q[DW-2:0], 1'b0};
						end
						dvd_q <= dvd_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end else begin
						// Round to nearest: remainder at least half the divisor.
						logic [DW:0] q;
						q = (DW+1)'(quo_q) +
							(DW+1)'(({1'b0, rem_q} << 1) >= {1'b0, c_q[0]});
						if (q > (DW+1)'(LIM_HI) + (DW+1)'(dneg_q))
							u_q <= dneg_q ? LIM_LO : LIM_HI;
						else
							u_q <= dneg_q ? W'(-q) : W'(q);
						step_q <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					unique case (step_q)
						4'd0: c1_q <= mres;
						4'd1: c2_q <= mres;
						4'd2: k_q <= mres;
						4'd3: t_q[0] <= mres;
						4'd4: t_q[1] <= mres;
						4'd5: t_q[2] <= mres;
						4'd6: t_q[0] <= mres;
						4'd7: t_q[3] <= mres;
						4'd8: t_q[1] <= mres;
						default: ;
					endcase
					if (step_q == 4'd5) f_q[1] <= sat(fsum);
					step_q <= step_q + 1'b1;
					if (step_q == 4'd8) state_q <= ST_FLUX;
				end
				ST_FLUX: begin
					f_q[0] <= c_q[1];
					f_q[2] <= sat(fdif);
					comp_q <= '0;
					emit_last_q <= 1'b0;
					if (first_q) begin
						if (last_q) state_q <= ST_EMUL;
						else state_q <= ST_WIN;
					end else begin
						state_q <= ST_EMUL;
					end
				end
				ST_EMUL: begin
					eprod_q <= edif * (PW+F+1)'(dtf_q);
					state_q <= ST_ESUM;
				end
				ST_ESUM: begin
					res_q[comp_q] <= eres;
					if (comp_q == 2'd2) state_q <= ST_OUT;
					else begin
						comp_q <= comp_q + 1'b1;
						state_q <= ST_EMUL;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_d_q <= pack;
						if (first_q) begin
							out_u_q <= {bad_q, 1'b1};
							fill_q <= '0;
							state_q <= ST_IDLE;
						end else if (!emit_last_q) begin
							out_u_q <= {(faults_q != 0) || bad_q, 1'b0};
							state_q <= last_q ? ST_CON : ST_WIN;
						end else begin
							out_u_q <= {faults_q[1] || bad_q, 1'b1};
							two_q <= 1'b0;
							state_q <= ST_WIN;
						end
					end
				end
				ST_CON: begin
					comp_q <= '0;
					emit_last_q <= 1'b1;
					two_q <= 1'b1;
					state_q <= ST_EMUL;
				end
				ST_WIN: begin
					for (int i = 0; i < 3; i++) begin
						ls_q[i] <= first_q ? c_q[i] : ms_q[i];
						lf_q[i] <= first_q ? f_q[i] : mf_q[i];
						ms_q[i] <= c_q[i];
						mf_q[i] <= f_q[i];
					end
					faults_q <= first_q ? {bad_q, bad_q} : {bad_q, faults_q[1]};
					fill_q <= (last_q && !first_q) ? 2'd0 : 2'd2;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: src/lax_euler_1d_step_chk.sv
// Port-level checker for the Lax-Friedrichs 1D Euler step block.
// Depends on lax_pkg for the default word width; bound to the top level.
module lax_euler_1d_step_chk #(
	parameter int WORD_BITS = lax_pkg::WORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [((3*WORD_BITS+7)/8)*8-1:0] m_tdata,
	input logic [1:0] m_tuser
);
	// A held result transaction keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");
	// No two accepts in consecutive cycles.
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");
	// When no result is held, none appears in the cycle right after an accept.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result too early");
endmodule

bind lax_euler_1d_step lax_euler_1d_step_chk #(.WORD_BITS(WORD_BITS)) u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser));
